// ===== rtl/core/ptf_pkg.sv =====
// Shared types, widths, command codes and the arithmetic step table of the
// polygon tangent frame core. Used by ptf_ctrl, ptf_dp and the top level.
package ptf_pkg;

   localparam int AXES = 3;          // x, y, z
   localparam int PW   = 32;         // Q16.16 position
   localparam int TXW  = 16;         // Q4.12 texture coordinate
   localparam int NW   = 16;         // Q1.14 normal / tangent
   localparam int EW   = PW + 1;     // edge vector component
   localparam int DW   = TXW + 1;    // texture delta
   localparam int MW   = 33;         // multiplier operand
   localparam int PRW  = 2 * MW;     // multiplier product
   localparam int ACW  = 86;         // accumulator
   localparam int CRW  = 2 * EW + 1; // cross product component
   localparam int DETW = 2 * DW + 1; // uv determinant
   localparam int TPW  = DW + EW + 1;// unnormalized tangent component
   localparam int NMW  = 30;         // magnitude bound after scaling
   localparam int SQW  = 64;         // square root operand
   localparam int LW   = 31;         // vector length
   localparam int FRB  = 14;         // Q1.14 fraction bits
   localparam int RMW  = NMW + FRB + 2;
   localparam int QW   = FRB + 1;    // quotient bits
   localparam int SQRT_STEPS = SQW / 2;
   localparam logic [QW-1:0] QMAX = QW'(1 << FRB);

   // Step table boundaries
   localparam logic [4:0] STEP_CROSS_END = 5'd7;
   localparam logic [4:0] STEP_TRI       = 5'd8;
   localparam logic [4:0] STEP_TRI_END   = 5'd26;
   localparam logic [4:0] STEP_SQ        = 5'd27;
   localparam logic [4:0] STEP_SQ_END    = 5'd31;

   // Result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NOTRI  = 2'd1;
   localparam logic [1:0] STATUS_UVZERO = 2'd2;

   typedef enum logic [3:0] {
      A_NONE, A_E0, A_E1, A_DU0, A_DU1, A_DV0, A_DV1, A_NRM, A_MAG
   } mul_a_type;

   typedef enum logic [3:0] {
      B_NONE, B_E0, B_E1, B_DV0, B_DV1, B_CRL, B_CRM, B_CRH, B_MAG
   } mul_b_type;

   typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_type;
   typedef enum logic [1:0] {SH_0, SH_32, SH_64} acc_sh_type;
   typedef enum logic [2:0] {DST_NONE, DST_CR, DST_DET, DST_TP, DST_DOT, DST_SUM} dst_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_ANCHOR, OP_EDGE, OP_ADVANCE, OP_DEGEN, OP_MAG, OP_SHIFT,
      OP_SQRT_STEP, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_DONE, OP_FINAL,
      OP_EMIT_OK, OP_EMIT_NOTRI
   } dp_op_type;

   typedef struct packed {
      mul_a_type  a_src;
      logic [1:0] a_idx;
      mul_b_type  b_src;
      logic [1:0] b_idx;
      acc_op_type acc;
      acc_sh_type sh;
      dst_type    dst;
      logic [1:0] dst_idx;
   } micro_type;

   typedef struct packed {
      logic      capture;
      micro_type mc;
      dp_op_type op;
      logic [1:0] k;
   } dp_cmd_type;

   typedef struct packed {
      logic cr_nz;
      logic det_zero;
      logic big;
      logic last;
   } dp_stat_type;

   function automatic micro_type mk(input mul_a_type a, input logic [1:0] ai,
                                    input mul_b_type b, input logic [1:0] bi,
                                    input acc_op_type op, input acc_sh_type sh,
                                    input dst_type d, input logic [1:0] di);
      micro_type m;
      m.a_src = a;   m.a_idx = ai;
      m.b_src = b;   m.b_idx = bi;
      m.acc = op;    m.sh = sh;
      m.dst = d;     m.dst_idx = di;
      return m;
   endfunction

   // Multiply/accumulate program: cross product, determinant, tangent,
   // normal dot cross, sum of squares. A store reads the accumulator once the
   // product of the multiply that last fed it is registered and accumulated.
   function automatic micro_type micro(input logic [4:0] step);
      micro_type m;
      m = '0;
      unique case (step)
         5'd0:  m = mk(A_E0, 2'd1, B_E1, 2'd2, ACC_LOAD, SH_0, DST_NONE, 2'd0);
         5'd1:  m = mk(A_E0, 2'd2, B_E1, 2'd1, ACC_SUB,  SH_0, DST_NONE, 2'd0);
         5'd2:  m = mk(A_E0, 2'd2, B_E1, 2'd0, ACC_LOAD, SH_0, DST_NONE, 2'd0);
         5'd3:  m = mk(A_E0, 2'd0, B_E1, 2'd2, ACC_SUB,  SH_0, DST_CR,   2'd0);
         5'd4:  m = mk(A_E0, 2'd0, B_E1, 2'd1, ACC_LOAD, SH_0, DST_NONE, 2'd0);
         5'd5:  m = mk(A_E0, 2'd1, B_E1, 2'd0, ACC_SUB,  SH_0, DST_CR,   2'd1);
         5'd6:  m = '0;
         5'd7:  m = mk(A_NONE, 2'd0, B_NONE, 2'd0, ACC_NONE, SH_0, DST_CR, 2'd2);
         5'd8:  m = mk(A_DU0, 2'd0, B_DV1, 2'd0, ACC_LOAD, SH_0, DST_NONE, 2'd0);
         5'd9:  m = mk(A_DU1, 2'd0, B_DV0, 2'd0, ACC_SUB,  SH_0, DST_NONE, 2'd0);
         5'd10: m = mk(A_DV1, 2'd0, B_E0, 2'd0, ACC_LOAD, SH_0, DST_NONE, 2'd0);
         5'd11: m = mk(A_DV0, 2'd0, B_E1, 2'd0, ACC_SUB,  SH_0, DST_DET,  2'd0);
         5'd12: m = mk(A_DV1, 2'd0, B_E0, 2'd1, ACC_LOAD, SH_0, DST_NONE, 2'd0);
         5'd13: m = mk(A_DV0, 2'd0, B_E1, 2'd1, ACC_SUB,  SH_0, DST_TP,   2'd0);
         5'd14: m = mk(A_DV1, 2'd0, B_E0, 2'd2, ACC_LOAD, SH_0, DST_NONE, 2'd0);
         5'd15: m = mk(A_DV0, 2'd0, B_E1, 2'd2, ACC_SUB,  SH_0, DST_TP,   2'd1);
         5'd16: m = mk(A_NRM, 2'd0, B_CRL, 2'd0, ACC_LOAD, SH_0,  DST_NONE, 2'd0);
         5'd17: m = mk(A_NRM, 2'd0, B_CRM, 2'd0, ACC_ADD,  SH_32, DST_TP,   2'd2);
         5'd18: m = mk(A_NRM, 2'd0, B_CRH, 2'd0, ACC_ADD,  SH_64, DST_NONE, 2'd0);
         5'd19: m = mk(A_NRM, 2'd1, B_CRL, 2'd1, ACC_ADD,  SH_0,  DST_NONE, 2'd0);
         5'd20: m = mk(A_NRM, 2'd1, B_CRM, 2'd1, ACC_ADD,  SH_32, DST_NONE, 2'd0);
         5'd21: m = mk(A_NRM, 2'd1, B_CRH, 2'd1, ACC_ADD,  SH_64, DST_NONE, 2'd0);
         5'd22: m = mk(A_NRM, 2'd2, B_CRL, 2'd2, ACC_ADD,  SH_0,  DST_NONE, 2'd0);
         5'd23: m = mk(A_NRM, 2'd2, B_CRM, 2'd2, ACC_ADD,  SH_32, DST_NONE, 2'd0);
         5'd24: m = mk(A_NRM, 2'd2, B_CRH, 2'd2, ACC_ADD,  SH_64, DST_NONE, 2'd0);
         5'd25: m = '0;
         5'd26: m = mk(A_NONE, 2'd0, B_NONE, 2'd0, ACC_NONE, SH_0, DST_DOT, 2'd0);
         5'd27: m = mk(A_MAG, 2'd0, B_MAG, 2'd0, ACC_LOAD, SH_0, DST_NONE, 2'd0);
         5'd28: m = mk(A_MAG, 2'd1, B_MAG, 2'd1, ACC_ADD,  SH_0, DST_NONE, 2'd0);
         5'd29: m = mk(A_MAG, 2'd2, B_MAG, 2'd2, ACC_ADD,  SH_0, DST_NONE, 2'd0);
         5'd30: m = '0;
         5'd31: m = mk(A_NONE, 2'd0, B_NONE, 2'd0, ACC_NONE, SH_0, DST_SUM, 2'd0);
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/core/ptf_dp.sv =====
// Datapath of the polygon tangent frame core: vertex stores, shared 33x33
// multiplier with accumulator, square root and divider units, result register.
// Depends on ptf_pkg; driven by commands from ptf_ctrl.
module ptf_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [31:0]        req_pos_x,
   input  logic signed [31:0]        req_pos_y,
   input  logic signed [31:0]        req_pos_z,
   input  logic signed [15:0]        req_tex_u,
   input  logic signed [15:0]        req_tex_v,
   input  logic signed [15:0]        req_normal_x,
   input  logic signed [15:0]        req_normal_y,
   input  logic signed [15:0]        req_normal_z,
   input  logic                      req_last_vertex,
   input  ptf_pkg::dp_cmd_type       cmd,
   output ptf_pkg::dp_stat_type      stat,
   output logic signed [15:0]        rsp_tangent_x,
   output logic signed [15:0]        rsp_tangent_y,
   output logic signed [15:0]        rsp_tangent_z,
   output logic                      rsp_handedness,
   output logic [1:0]                rsp_status
);

   logic signed [ptf_pkg::PW-1:0]   cur_pos_ff [ptf_pkg::AXES];
   logic signed [ptf_pkg::TXW-1:0]  cur_tex_ff [2];
   logic signed [ptf_pkg::NW-1:0]   cur_nrm_ff [ptf_pkg::AXES];
   logic                            last_ff;
   logic signed [ptf_pkg::PW-1:0]   anc_pos_ff [ptf_pkg::AXES];
   logic signed [ptf_pkg::TXW-1:0]  anc_tex_ff [2];
   logic signed [ptf_pkg::NW-1:0]   nrm_ff [ptf_pkg::AXES];
   logic signed [ptf_pkg::PW-1:0]   prv_pos_ff [ptf_pkg::AXES];
   logic signed [ptf_pkg::TXW-1:0]  prv_tex_ff [2];
   logic signed [ptf_pkg::EW-1:0]   e0_ff [ptf_pkg::AXES];
   logic signed [ptf_pkg::EW-1:0]   e1_ff [ptf_pkg::AXES];
   logic signed [ptf_pkg::DW-1:0]   du0_ff, dv0_ff, du1_ff, dv1_ff;

   logic signed [ptf_pkg::MW-1:0]   a_op, b_op;
   logic signed [ptf_pkg::PRW-1:0]  prod_ff;
   ptf_pkg::acc_op_type             pend_op_ff;
   ptf_pkg::acc_sh_type             pend_sh_ff;
   logic signed [ptf_pkg::ACW-1:0]  acc_ff, acc_in, prod_ext, prod_sh;

   logic signed [ptf_pkg::CRW-1:0]  cr_ff [ptf_pkg::AXES];
   logic signed [ptf_pkg::DETW-1:0] det_ff;
   logic signed [ptf_pkg::TPW-1:0]  tp_ff [ptf_pkg::AXES];
   logic                            dot_neg_ff, dot_zero_ff;
   logic [ptf_pkg::TPW-1:0]         mag_ff [ptf_pkg::AXES];
   logic                            neg_ff [ptf_pkg::AXES];

   logic [ptf_pkg::SQW-1:0]         x_ff, res_ff, bit_ff, sq_trial;
   logic [ptf_pkg::RMW-1:0]         rem_ff, dvs_ff;
   logic [ptf_pkg::QW-1:0]          quo_ff, quo_clip;

   logic signed [ptf_pkg::NW-1:0]   tan_ff [ptf_pkg::AXES];
   logic                            hand_ff;
   logic [1:0]                      stat_ff;

   logic signed [ptf_pkg::NW-1:0]   out_tan_ff [ptf_pkg::AXES];
   logic                            out_hand_ff;
   logic [1:0]                      out_stat_ff;

   function automatic logic signed [ptf_pkg::EW-1:0] EW_SUB(
      input logic signed [ptf_pkg::PW-1:0] a, input logic signed [ptf_pkg::PW-1:0] b);
      logic signed [ptf_pkg::EW-1:0] ea, eb;
      ea = {a[ptf_pkg::PW-1], a};
      eb = {b[ptf_pkg::PW-1], b};
      return ea - eb;
   endfunction

   function automatic logic signed [ptf_pkg::DW-1:0] DW_SUB(
      input logic signed [ptf_pkg::TXW-1:0] a, input logic signed [ptf_pkg::TXW-1:0] b);
      logic signed [ptf_pkg::DW-1:0] ea, eb;
      ea = {a[ptf_pkg::TXW-1], a};
      eb = {b[ptf_pkg::TXW-1], b};
      return ea - eb;
   endfunction

   // Select multiplier operands
   always_comb begin
      a_op = '0;
      unique case (cmd.mc.a_src)
         ptf_pkg::A_NONE: a_op = '0;
         ptf_pkg::A_E0:   a_op = e0_ff[cmd.mc.a_idx];
         ptf_pkg::A_E1:   a_op = e1_ff[cmd.mc.a_idx];
         ptf_pkg::A_DU0:  a_op = {{(ptf_pkg::MW-ptf_pkg::DW){du0_ff[ptf_pkg::DW-1]}}, du0_ff};
         ptf_pkg::A_DU1:  a_op = {{(ptf_pkg::MW-ptf_pkg::DW){du1_ff[ptf_pkg::DW-1]}}, du1_ff};
         ptf_pkg::A_DV0:  a_op = {{(ptf_pkg::MW-ptf_pkg::DW){dv0_ff[ptf_pkg::DW-1]}}, dv0_ff};
         ptf_pkg::A_DV1:  a_op = {{(ptf_pkg::MW-ptf_pkg::DW){dv1_ff[ptf_pkg::DW-1]}}, dv1_ff};
         ptf_pkg::A_NRM:  a_op = {{(ptf_pkg::MW-ptf_pkg::NW){nrm_ff[cmd.mc.a_idx][ptf_pkg::NW-1]}},
                                  nrm_ff[cmd.mc.a_idx]};
         ptf_pkg::A_MAG:  a_op = {{(ptf_pkg::MW-ptf_pkg::NMW){1'b0}},
                                  mag_ff[cmd.mc.a_idx][ptf_pkg::NMW-1:0]};
         default:         a_op = '0;
      endcase
   end

   always_comb begin
      b_op = '0;
      unique case (cmd.mc.b_src)
         ptf_pkg::B_NONE: b_op = '0;
         ptf_pkg::B_E0:   b_op = e0_ff[cmd.mc.b_idx];
         ptf_pkg::B_E1:   b_op = e1_ff[cmd.mc.b_idx];
         ptf_pkg::B_DV0:  b_op = {{(ptf_pkg::MW-ptf_pkg::DW){dv0_ff[ptf_pkg::DW-1]}}, dv0_ff};
         ptf_pkg::B_DV1:  b_op = {{(ptf_pkg::MW-ptf_pkg::DW){dv1_ff[ptf_pkg::DW-1]}}, dv1_ff};
         ptf_pkg::B_CRL:  b_op = {1'b0, cr_ff[cmd.mc.b_idx][31:0]};
         ptf_pkg::B_CRM:  b_op = {1'b0, cr_ff[cmd.mc.b_idx][63:32]};
         ptf_pkg::B_CRH:  b_op = {{(ptf_pkg::MW-3){cr_ff[cmd.mc.b_idx][ptf_pkg::CRW-1]}},
                                  cr_ff[cmd.mc.b_idx][ptf_pkg::CRW-1:64]};
         ptf_pkg::B_MAG:  b_op = {{(ptf_pkg::MW-ptf_pkg::NMW){1'b0}},
                                  mag_ff[cmd.mc.b_idx][ptf_pkg::NMW-1:0]};
         default:         b_op = '0;
      endcase
   end

   // Align the registered product and accumulate
   assign prod_ext = {{(ptf_pkg::ACW-ptf_pkg::PRW){prod_ff[ptf_pkg::PRW-1]}}, prod_ff};

   always_comb begin
      prod_sh = prod_ext;
      unique case (pend_sh_ff)
         ptf_pkg::SH_0:  prod_sh = prod_ext;
         ptf_pkg::SH_32: prod_sh = prod_ext <<< 32;
         ptf_pkg::SH_64: prod_sh = prod_ext <<< 64;
         default:        prod_sh = prod_ext;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      unique case (pend_op_ff)
         ptf_pkg::ACC_NONE: acc_in = acc_ff;
         ptf_pkg::ACC_LOAD: acc_in = prod_sh;
         ptf_pkg::ACC_ADD:  acc_in = acc_ff + prod_sh;
         ptf_pkg::ACC_SUB:  acc_in = acc_ff - prod_sh;
         default:           acc_in = acc_ff;
      endcase
   end

   // Square root trial and quotient limit
   assign sq_trial = res_ff + bit_ff;
   assign quo_clip = (quo_ff > ptf_pkg::QMAX) ? ptf_pkg::QMAX : quo_ff;

   // Hold the pending accumulate operation for the product in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_op_ff <= ptf_pkg::ACC_NONE;
         pend_sh_ff <= ptf_pkg::SH_0;
      end else begin
         pend_op_ff <= cmd.mc.acc;
         pend_sh_ff <= cmd.mc.sh;
      end
   end

   // Multiply, accumulate and store
   always_ff @(posedge clock) begin
      prod_ff <= a_op * b_op;
      acc_ff  <= acc_in;
      unique case (cmd.mc.dst)
         ptf_pkg::DST_NONE: ;
         ptf_pkg::DST_CR:   cr_ff[cmd.mc.dst_idx] <= acc_ff[ptf_pkg::CRW-1:0];
         ptf_pkg::DST_DET:  det_ff <= acc_ff[ptf_pkg::DETW-1:0];
         ptf_pkg::DST_TP:   tp_ff[cmd.mc.dst_idx] <= acc_ff[ptf_pkg::TPW-1:0];
         ptf_pkg::DST_DOT: begin
            dot_neg_ff  <= acc_ff[ptf_pkg::ACW-1];
            dot_zero_ff <= (acc_ff == '0);
         end
         ptf_pkg::DST_SUM: ;
         default: ;
      endcase
   end

   // Capture the transfer and run vertex, scaling and result operations
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_pos_ff[0] <= req_pos_x;
         cur_pos_ff[1] <= req_pos_y;
         cur_pos_ff[2] <= req_pos_z;
         cur_tex_ff[0] <= req_tex_u;
         cur_tex_ff[1] <= req_tex_v;
         cur_nrm_ff[0] <= req_normal_x;
         cur_nrm_ff[1] <= req_normal_y;
         cur_nrm_ff[2] <= req_normal_z;
         last_ff       <= req_last_vertex;
      end
      // Load the square root unit from the sum of squares
      if (cmd.mc.dst == ptf_pkg::DST_SUM) begin
         x_ff   <= acc_ff[ptf_pkg::SQW-1:0];
         res_ff <= '0;
         bit_ff <= ptf_pkg::SQW'(1) << (ptf_pkg::SQW - 2);
      end
      unique case (cmd.op)
         ptf_pkg::OP_NONE: ;
         ptf_pkg::OP_ANCHOR: begin
            anc_pos_ff <= cur_pos_ff;
            anc_tex_ff <= cur_tex_ff;
            nrm_ff     <= cur_nrm_ff;
         end
         ptf_pkg::OP_EDGE: begin
            for (int i = 0; i < ptf_pkg::AXES; i++) begin
               e0_ff[i] <= EW_SUB(prv_pos_ff[i], anc_pos_ff[i]);
               e1_ff[i] <= EW_SUB(cur_pos_ff[i], anc_pos_ff[i]);
            end
            du0_ff <= DW_SUB(prv_tex_ff[0], anc_tex_ff[0]);
            dv0_ff <= DW_SUB(prv_tex_ff[1], anc_tex_ff[1]);
            du1_ff <= DW_SUB(cur_tex_ff[0], anc_tex_ff[0]);
            dv1_ff <= DW_SUB(cur_tex_ff[1], anc_tex_ff[1]);
         end
         ptf_pkg::OP_ADVANCE: begin
            prv_pos_ff <= cur_pos_ff;
            prv_tex_ff <= cur_tex_ff;
         end
         ptf_pkg::OP_DEGEN: begin
            for (int i = 0; i < ptf_pkg::AXES; i++) tan_ff[i] <= '0;
            hand_ff <= 1'b0;
            stat_ff <= ptf_pkg::STATUS_UVZERO;
         end
         ptf_pkg::OP_MAG: begin
            for (int i = 0; i < ptf_pkg::AXES; i++) begin
               neg_ff[i] <= tp_ff[i][ptf_pkg::TPW-1] ^ det_ff[ptf_pkg::DETW-1];
               mag_ff[i] <= tp_ff[i][ptf_pkg::TPW-1] ? ptf_pkg::TPW'(-tp_ff[i])
                                                     : ptf_pkg::TPW'(tp_ff[i]);
            end
         end
         ptf_pkg::OP_SHIFT: begin
            for (int i = 0; i < ptf_pkg::AXES; i++) mag_ff[i] <= mag_ff[i] >> 1;
         end
         ptf_pkg::OP_SQRT_STEP: begin
            if (x_ff >= sq_trial) begin
               x_ff   <= x_ff - sq_trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ptf_pkg::OP_DIV_INIT: begin
            rem_ff <= {2'b00, mag_ff[cmd.k][ptf_pkg::NMW-1:0], {ptf_pkg::FRB{1'b0}}}
                      + ptf_pkg::RMW'(res_ff[ptf_pkg::LW-1:1]);
            dvs_ff <= {1'b0, res_ff[ptf_pkg::LW-1:0], {ptf_pkg::FRB{1'b0}}};
            quo_ff <= '0;
         end
         ptf_pkg::OP_DIV_STEP: begin
            if (rem_ff >= dvs_ff) begin
               rem_ff <= rem_ff - dvs_ff;
               quo_ff <= {quo_ff[ptf_pkg::QW-2:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[ptf_pkg::QW-2:0], 1'b0};
            end
            dvs_ff <= dvs_ff >> 1;
         end
         ptf_pkg::OP_DIV_DONE: begin
            tan_ff[cmd.k] <= neg_ff[cmd.k] ? -ptf_pkg::NW'(quo_clip) : ptf_pkg::NW'(quo_clip);
         end
         ptf_pkg::OP_FINAL: begin
            hand_ff <= !dot_zero_ff && (dot_neg_ff != det_ff[ptf_pkg::DETW-1]);
            stat_ff <= ptf_pkg::STATUS_OK;
         end
         ptf_pkg::OP_EMIT_OK: begin
            out_tan_ff  <= tan_ff;
            out_hand_ff <= hand_ff;
            out_stat_ff <= stat_ff;
         end
         ptf_pkg::OP_EMIT_NOTRI: begin
            for (int i = 0; i < ptf_pkg::AXES; i++) out_tan_ff[i] <= '0;
            out_hand_ff <= 1'b0;
            out_stat_ff <= ptf_pkg::STATUS_NOTRI;
         end
         default: ;
      endcase
   end

   // Status to the controller
   assign stat.cr_nz    = (|cr_ff[0]) | (|cr_ff[1]) | (|cr_ff[2]);
   assign stat.det_zero = (det_ff == '0);
   assign stat.big      = (|mag_ff[0][ptf_pkg::TPW-1:ptf_pkg::NMW])
                        | (|mag_ff[1][ptf_pkg::TPW-1:ptf_pkg::NMW])
                        | (|mag_ff[2][ptf_pkg::TPW-1:ptf_pkg::NMW]);
   assign stat.last     = last_ff;

   assign rsp_tangent_x  = out_tan_ff[0];
   assign rsp_tangent_y  = out_tan_ff[1];
   assign rsp_tangent_z  = out_tan_ff[2];
   assign rsp_handedness = out_hand_ff;
   assign rsp_status     = out_stat_ff;

endmodule

// ===== rtl/core/ptf_ctrl.sv =====
// Controller of the polygon tangent frame core: vertex phase tracking,
// sequencing of the arithmetic steps, handshakes. Depends on ptf_pkg.
module ptf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ptf_pkg::dp_stat_type stat,
   output ptf_pkg::dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISP, S_CROSS, S_CHECK, S_TRI, S_DETCHK, S_NORM, S_SQ,
      S_SQRT, S_DIVI, S_DIV, S_DIVD, S_FIN, S_WRAP, S_EMIT
   } state_type;

   typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_FAN} phase_type;

   state_type  state_ff;
   phase_type  phase_ff;
   logic       found_ff;
   logic [4:0] step_ff;
   logic [4:0] cnt_ff;
   logic [1:0] k_ff;
   logic       rsp_valid_ff;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Decode commands for the datapath
   always_comb begin
      cmd = '0;
      cmd.capture = accept;
      cmd.k = k_ff;
      unique case (state_ff)
         S_DISP: begin
            if (phase_ff == PH_FIRST) cmd.op = ptf_pkg::OP_ANCHOR;
            else if (phase_ff == PH_FAN && !found_ff) cmd.op = ptf_pkg::OP_EDGE;
         end
         S_CROSS, S_TRI, S_SQ: cmd.mc = ptf_pkg::micro(step_ff);
         S_DETCHK: cmd.op = stat.det_zero ? ptf_pkg::OP_DEGEN : ptf_pkg::OP_MAG;
         S_NORM:   if (stat.big) cmd.op = ptf_pkg::OP_SHIFT;
         S_SQRT:   cmd.op = ptf_pkg::OP_SQRT_STEP;
         S_DIVI:   cmd.op = ptf_pkg::OP_DIV_INIT;
         S_DIV:    cmd.op = ptf_pkg::OP_DIV_STEP;
         S_DIVD:   cmd.op = ptf_pkg::OP_DIV_DONE;
         S_FIN:    cmd.op = ptf_pkg::OP_FINAL;
         S_WRAP:   cmd.op = ptf_pkg::OP_ADVANCE;
         S_EMIT: begin
            if (out_free) cmd.op = found_ff ? ptf_pkg::OP_EMIT_OK : ptf_pkg::OP_EMIT_NOTRI;
         end
         default: ;
      endcase
   end

   // Advance state, counters and the result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_FIRST;
         found_ff     <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Present a new result, or drop the one just transferred
         if (state_ff == S_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (accept) state_ff <= S_DISP;
            S_DISP: begin
               if (phase_ff == PH_FIRST) begin
                  phase_ff <= PH_SECOND;
                  found_ff <= 1'b0;
                  state_ff <= S_WRAP;
               end else begin
                  phase_ff <= PH_FAN;
                  if (phase_ff == PH_FAN && !found_ff) begin
                     step_ff  <= '0;
                     state_ff <= S_CROSS;
                  end else begin
                     state_ff <= S_WRAP;
                  end
               end
            end
            S_CROSS: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == ptf_pkg::STEP_CROSS_END) state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (stat.cr_nz) begin
                  step_ff  <= ptf_pkg::STEP_TRI;
                  state_ff <= S_TRI;
               end else begin
                  state_ff <= S_WRAP;
               end
            end
            S_TRI: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == ptf_pkg::STEP_TRI_END) state_ff <= S_DETCHK;
            end
            S_DETCHK: begin
               if (stat.det_zero) begin
                  found_ff <= 1'b1;
                  state_ff <= S_WRAP;
               end else begin
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (!stat.big) begin
                  step_ff  <= ptf_pkg::STEP_SQ;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == ptf_pkg::STEP_SQ_END) begin
                  cnt_ff   <= '0;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(ptf_pkg::SQRT_STEPS - 1)) begin
                  k_ff     <= '0;
                  state_ff <= S_DIVI;
               end
            end
            S_DIVI: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(ptf_pkg::QW - 1)) state_ff <= S_DIVD;
            end
            S_DIVD: begin
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'(ptf_pkg::AXES - 1)) state_ff <= S_FIN;
               else state_ff <= S_DIVI;
            end
            S_FIN: begin
               found_ff <= 1'b1;
               state_ff <= S_WRAP;
            end
            S_WRAP: state_ff <= stat.last ? S_EMIT : S_IDLE;
            S_EMIT: begin
               if (out_free) begin
                  phase_ff     <= PH_FIRST;
                  found_ff     <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_accept_disp: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_DISP))
      else $error("transfer not followed by dispatch");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> rsp_valid_ff)
      else $error("result not presented after emit");

   a_found_src: assert property (@(posedge clock) disable iff (reset)
      $rose(found_ff) |-> ($past(state_ff) == S_FIN || $past(state_ff) == S_DETCHK))
      else $error("triangle latch set outside finish");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff < 5'(ptf_pkg::QW)))
      else $error("divider ran past quotient width");

endmodule

// ===== rtl/core/polygon_tangent_frame_core.sv =====
// Top level of the polygon tangent frame core: joins controller and datapath.
// Depends on ptf_pkg, ptf_ctrl and ptf_dp.
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    pos_x/y/z, tex_u/v, normal_x/y/z, last_vertex
//   rsp_      out        rsp_valid/stall    tangent_x/y/z, handedness, status
//
// A vertex passes through transfer, dispatch and wrap-up; a fan vertex tested
// for a nonzero cross product also runs the cross product on the shared 33x33
// multiplier and a check. The vertex that latches a triangle adds the multiply
// steps, a determinant check and, unless the determinant is zero, scaling,
// squares, square-root steps, a divider run per axis and a finish step.
// The last vertex also loads the result, waiting while the result register
// is not free. Reset is synchronous and clears all control state.
// The result register holds while rsp_valid and rsp_stall are both high; the
// next vertex is still taken meanwhile.
module polygon_tangent_frame_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_tex_u,
   input  logic signed [15:0] req_tex_v,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic               req_last_vertex,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_tangent_x,
   output logic signed [15:0] rsp_tangent_y,
   output logic signed [15:0] rsp_tangent_z,
   output logic               rsp_handedness,
   output logic [1:0]         rsp_status
);

   ptf_pkg::dp_cmd_type  cmd;
   ptf_pkg::dp_stat_type stat;

   ptf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_tex_u       (req_tex_u),
      .req_tex_v       (req_tex_v),
      .req_normal_x    (req_normal_x),
      .req_normal_y    (req_normal_y),
      .req_normal_z    (req_normal_z),
      .req_last_vertex (req_last_vertex),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_tangent_x   (rsp_tangent_x),
      .rsp_tangent_y   (rsp_tangent_y),
      .rsp_tangent_z   (rsp_tangent_z),
      .rsp_handedness  (rsp_handedness),
      .rsp_status      (rsp_status)
   );

endmodule
